// ===== design/cbts_pkg.sv =====
// Shared types and constants for the CAN bit timing search.
// No dependencies.
package cbts_pkg;

	localparam int PRESC_LIMIT = 1024;
	localparam int SEG1_LIMIT  = 15;
	localparam int SEG2_LIMIT  = 7;
	localparam int MIN_RATE    = 10;

	localparam int RATE_W  = 24;
	localparam int CLK_W   = 32;
	localparam int CFG_W   = 7;
	localparam int PRESC_W = 10;
	localparam int SEG1_W  = 4;
	localparam int SEG2_W  = 3;
	localparam int TOT_W   = 5;
	localparam int DRATE_W = 35;
	localparam int BOUND_W = 40;
	localparam int LHS_W   = 42;

	typedef enum logic [1:0] {
		REG_CLOCK_HZ  = 2'd0,
		REG_TOLERANCE = 2'd1,
		REG_TARGET    = 2'd2,
		REG_SLACK     = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		STAT_FOUND = 2'd0,
		STAT_LOW   = 2'd1,
		STAT_NONE  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_LHS,
		S_SCAN
	} state_t;

endpackage

// ===== design/cbts_div.sv =====
// Iterative restoring divider: 32-bit dividend by 10-bit divisor, one bit a cycle.
// Depends on cbts_pkg.
module cbts_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cbts_pkg::CLK_W-1:0]    dividend,
	input  logic [cbts_pkg::PRESC_W-1:0]  divisor,
	output logic                          done,
	output logic [cbts_pkg::CLK_W-1:0]    quotient
);

	logic                          run_q;
	logic                          done_q;
	logic [4:0]                    cnt_q;
	logic [cbts_pkg::CLK_W-1:0]    quo_q;
	logic [cbts_pkg::PRESC_W-1:0]  rem_q;
	logic [cbts_pkg::PRESC_W-1:0]  dvs_q;
	logic [cbts_pkg::PRESC_W:0]    trial;
	logic                          fits;

	assign trial = {rem_q, quo_q[cbts_pkg::CLK_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[cbts_pkg::CLK_W-2:0], fits};
			if (fits) begin
				rem_q <= cbts_pkg::PRESC_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[cbts_pkg::PRESC_W-1:0];
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== design/can_bit_timing_search.sv =====
// CAN bit timing search: finds prescaler and segment codes for a requested bit rate.
// Depends on cbts_pkg and cbts_div.
// A refused rate (10 or less) answers in the cycle after start. A search tries each
// prescaler in turn (the shared serial divider and the quanta product, then a scan of
// the 105 segment pairs through a two-stage compare); busy stays high meanwhile.
// done strobes each result for one cycle. Reset loads the register defaults and idles.
module can_bit_timing_search (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [31:0]                     cfg_wdata,
	input  logic                            start,
	input  logic [cbts_pkg::RATE_W-1:0]     desired_rate,
	output logic                            busy,
	output logic                            done,
	output logic [1:0]                      status,
	output logic [cbts_pkg::PRESC_W-1:0]    prescaler_value,
	output logic [cbts_pkg::SEG1_W-1:0]     seg1_code,
	output logic [cbts_pkg::SEG2_W-1:0]     seg2_code
);

	localparam logic [cbts_pkg::PRESC_W-1:0] P_LAST = cbts_pkg::PRESC_W'(cbts_pkg::PRESC_LIMIT - 1);
	localparam logic [cbts_pkg::SEG1_W-1:0]  S1_LAST = cbts_pkg::SEG1_W'(cbts_pkg::SEG1_LIMIT - 1);
	localparam logic [cbts_pkg::SEG2_W-1:0]  S2_LAST = cbts_pkg::SEG2_W'(cbts_pkg::SEG2_LIMIT - 1);

	cbts_pkg::state_t state_q, state_d;

	logic [cbts_pkg::CLK_W-1:0]    clock_hz_q;
	logic [cbts_pkg::CFG_W-1:0]    tol_q;
	logic [cbts_pkg::CFG_W-1:0]    target_q;
	logic [cbts_pkg::CFG_W-1:0]    slack_q;

	logic [cbts_pkg::DRATE_W-1:0]  dhi_q;
	logic [cbts_pkg::DRATE_W-1:0]  dlo_q;
	logic [cbts_pkg::LHS_W-1:0]    lhs_q;
	logic [cbts_pkg::PRESC_W-1:0]  p_q;
	logic [cbts_pkg::SEG1_W-1:0]   cs1_q;
	logic [cbts_pkg::SEG2_W-1:0]   cs2_q;
	logic                          issued_q;

	logic                          v_s1;
	logic [cbts_pkg::SEG1_W-1:0]   s1c_s1;
	logic [cbts_pkg::SEG2_W-1:0]   s2c_s1;
	logic [cbts_pkg::BOUND_W-1:0]  hi_s1;
	logic [cbts_pkg::BOUND_W-1:0]  lo_s1;
	logic                          sok_s1;

	logic                          done_q;
	cbts_pkg::status_t             status_q;
	logic [cbts_pkg::PRESC_W-1:0]  presc_q;
	logic [cbts_pkg::SEG1_W-1:0]   seg1_q;
	logic [cbts_pkg::SEG2_W-1:0]   seg2_q;

	logic                          accept;
	logic                          too_low;
	logic                          div_start;
	logic [cbts_pkg::PRESC_W-1:0]  div_divisor;
	logic                          div_done;
	logic [cbts_pkg::CLK_W-1:0]    div_quo;

	logic [cbts_pkg::TOT_W-1:0]    total;
	logic [10:0]                   num;
	logic [8:0]                    top_p1;
	logic [12:0]                   top_prod;
	logic [cbts_pkg::CFG_W-1:0]    bot;
	logic [11:0]                   bot_prod;
	logic                          sample_ok;
	logic                          hit;
	logic                          last_eval;
	logic                          exhausted;

	assign accept  = start && (state_q == cbts_pkg::S_IDLE);
	assign too_low = desired_rate <= cbts_pkg::RATE_W'(cbts_pkg::MIN_RATE);

	// candidate sample point window, by cross-multiplication
	assign total    = cbts_pkg::TOT_W'(cs1_q) + cbts_pkg::TOT_W'(cs2_q) + 5'd3;
	assign num      = 11'(7'd100 * (11'(cs1_q) + 11'd2));
	assign top_p1   = 9'(target_q) + 9'(slack_q) + 9'd1;
	assign top_prod = 13'(top_p1) * 13'(total);
	assign bot      = cbts_pkg::CFG_W'(target_q - slack_q);
	assign bot_prod = 12'(bot) * 12'(total);
	assign sample_ok = (13'(num) < top_prod) && ((target_q < slack_q) || (12'(num) >= bot_prod));

	assign hit = v_s1 && sok_s1 && ({2'b0, hi_s1} >= lhs_q) && (lhs_q >= {2'b0, lo_s1});
	assign last_eval = v_s1 && (s1c_s1 == S1_LAST) && (s2c_s1 == S2_LAST);
	assign exhausted = !hit && last_eval && (p_q == P_LAST);

	assign div_divisor = (state_q == cbts_pkg::S_IDLE) ? cbts_pkg::PRESC_W'(1) :
		cbts_pkg::PRESC_W'(p_q + 10'd1);

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		unique case (state_q)
			cbts_pkg::S_IDLE: begin
				if (accept && !too_low) begin
					div_start = 1'b1;
					state_d   = cbts_pkg::S_DIV;
				end
			end
			cbts_pkg::S_DIV: begin
				if (div_done) begin
					state_d = cbts_pkg::S_LHS;
				end
			end
			cbts_pkg::S_LHS: begin
				state_d = cbts_pkg::S_SCAN;
			end
			cbts_pkg::S_SCAN: begin
				if (hit || exhausted) begin
					state_d = cbts_pkg::S_IDLE;
				end else if (last_eval) begin
					div_start = 1'b1;
					state_d   = cbts_pkg::S_DIV;
				end
			end
			default: state_d = cbts_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbts_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= 32'd72000000;
			tol_q      <= 7'd5;
			target_q   <= 7'd75;
			slack_q    <= 7'd10;
		end else if (cfg_we) begin
			unique case (cbts_pkg::reg_idx_t'(cfg_index))
				cbts_pkg::REG_CLOCK_HZ:  clock_hz_q <= cfg_wdata;
				cbts_pkg::REG_TOLERANCE: tol_q      <= cfg_wdata[cbts_pkg::CFG_W-1:0];
				cbts_pkg::REG_TARGET:    target_q   <= cfg_wdata[cbts_pkg::CFG_W-1:0];
				cbts_pkg::REG_SLACK:     slack_q    <= cfg_wdata[cbts_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q      <= '0;
			cs1_q    <= '0;
			cs2_q    <= '0;
			issued_q <= 1'b0;
			v_s1     <= 1'b0;
			done_q   <= 1'b0;
			status_q <= cbts_pkg::STAT_FOUND;
			presc_q  <= '0;
			seg1_q   <= '0;
			seg2_q   <= '0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= 1'b0;
			if (div_start) begin
				p_q <= div_divisor;
			end
			if (state_q == cbts_pkg::S_LHS) begin
				cs1_q    <= '0;
				cs2_q    <= '0;
				issued_q <= 1'b0;
			end else if (state_q == cbts_pkg::S_SCAN && !issued_q && !hit) begin
				v_s1 <= 1'b1;
				if (cs2_q == S2_LAST) begin
					cs2_q <= '0;
					if (cs1_q == S1_LAST) begin
						issued_q <= 1'b1;
					end else begin
						cs1_q <= cs1_q + 4'd1;
					end
				end else begin
					cs2_q <= cs2_q + 3'd1;
				end
			end
			if (accept && too_low) begin
				done_q   <= 1'b1;
				status_q <= cbts_pkg::STAT_LOW;
				presc_q  <= '0;
				seg1_q   <= '0;
				seg2_q   <= '0;
			end else if (state_q == cbts_pkg::S_SCAN && hit) begin
				done_q   <= 1'b1;
				status_q <= cbts_pkg::STAT_FOUND;
				presc_q  <= p_q;
				seg1_q   <= s1c_s1;
				seg2_q   <= s2c_s1;
			end else if (state_q == cbts_pkg::S_SCAN && exhausted) begin
				done_q   <= 1'b1;
				status_q <= cbts_pkg::STAT_NONE;
				presc_q  <= '0;
				seg1_q   <= '0;
				seg2_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dhi_q <= cbts_pkg::DRATE_W'(desired_rate) *
				cbts_pkg::DRATE_W'(11'd1000 + 11'(tol_q));
			dlo_q <= cbts_pkg::DRATE_W'(desired_rate) *
				cbts_pkg::DRATE_W'(11'd1000 - 11'(tol_q));
		end
		if (state_q == cbts_pkg::S_LHS) begin
			lhs_q <= cbts_pkg::LHS_W'(div_quo) * cbts_pkg::LHS_W'(1000);
		end
		s1c_s1 <= cs1_q;
		s2c_s1 <= cs2_q;
		hi_s1  <= cbts_pkg::BOUND_W'(dhi_q) * cbts_pkg::BOUND_W'(total);
		lo_s1  <= cbts_pkg::BOUND_W'(dlo_q) * cbts_pkg::BOUND_W'(total);
		sok_s1 <= sample_ok;
	end

	cbts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (clock_hz_q),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign busy            = state_q != cbts_pkg::S_IDLE;
	assign done            = done_q;
	assign status          = status_q;
	assign prescaler_value = presc_q;
	assign seg1_code       = seg1_q;
	assign seg2_code       = seg2_q;

endmodule
